>>> hw/rtl/garage_door_controller_top_macros.svh
// Assertion macros for the garage door controller.
// Included by the top level; no other dependencies.
`ifndef GARAGE_DOOR_CONTROLLER_TOP_MACROS_SVH
`define GARAGE_DOOR_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("garage door controller check failed");
`define GDC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("garage door controller check failed");
`else
`define GDC_ASSERT(lbl, prop)
`define GDC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/gdc_pkg.sv
// Shared types and constants for the garage door controller.
// No dependencies.
package gdc_pkg;

  localparam int unsigned StableW = 11;
  localparam int unsigned TimerW  = 17;
  localparam int unsigned DebW    = 10;
  localparam int unsigned MaxW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DebW-1:0] DebounceRst = DebW'(100);
  localparam logic [MaxW-1:0] MaxRunRst   = MaxW'(13000);
  localparam logic [MaxW-1:0] MaxLampRst  = MaxW'(30000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_MAX_RUN_MS  = 2'd1,
    REG_MAX_LAMP_MS = 2'd2
  } gdc_reg_e;

  // Debounced events seen by the door and lamp control.
  typedef struct packed {
    logic wall_press;
    logic light_press;
    logic up_level;
    logic dn_level;
  } gdc_events_t;

  typedef struct packed {
    logic moving;
    logic going_up;
    logic lamp_on;
  } gdc_status_t;

endpackage

>>> hw/rtl/gdc_debounce.sv
// One pin debouncer with stable-time counter and accepted level.
// Depends on gdc_pkg.
module gdc_debounce import gdc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            tick_i,
  input  logic            pin_i,
  input  logic            blank_low_i,
  input  logic [DebW-1:0] debounce_ms_i,
  output logic            fire_o,
  output logic            level_o
);

  logic               prev_q, prev_d;
  logic               known_q, known_d;
  logic               level_q, level_d;
  logic [StableW-1:0] stable_q, stable_d, stable_inc;
  logic               differ;

  always_comb begin
    stable_inc = (tick_i && (stable_q != '1)) ? stable_q + StableW'(1) : stable_q;
    // With no level accepted yet, a limit pin behaves as if low was accepted,
    // whereas a button accepts whatever first settles.
    differ = blank_low_i ? (pin_i != (known_q & level_q))
                         : (!known_q || (pin_i != level_q));
    prev_d   = pin_i;
    known_d  = known_q;
    level_d  = level_q;
    fire_o   = 1'b0;
    if (pin_i != prev_q) begin
      stable_d = '0;
    end else begin
      stable_d = stable_inc;
      fire_o   = (stable_inc > {1'b0, debounce_ms_i}) && differ;
    end
    if (fire_o) begin
      known_d = 1'b1;
      level_d = pin_i;
    end
    level_o = known_d & level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      known_q  <= 1'b0;
      level_q  <= 1'b0;
      stable_q <= '0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      known_q  <= known_d;
      level_q  <= level_d;
      stable_q <= stable_d;
    end
  end

endmodule

>>> hw/rtl/gdc_ctrl.sv
// Door motion, lamp and timer control for one poll of the pins.
// Depends on gdc_pkg.
module gdc_ctrl import gdc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            tick_i,
  input  logic            radio_i,
  input  gdc_events_t     ev_i,
  input  logic [MaxW-1:0] max_run_ms_i,
  input  logic [MaxW-1:0] max_lamp_ms_i,
  output gdc_status_t     status_d_o,
  output gdc_status_t     status_q_o
);

  gdc_status_t       st_q, st_d;
  logic              radio_prev_q, radio_prev_d;
  logic [TimerW-1:0] run_q, run_d, lamp_tmr_q, lamp_tmr_d;
  logic              toggle;

  always_comb begin
    st_d       = st_q;
    run_d      = (tick_i && (run_q != '1)) ? run_q + TimerW'(1) : run_q;
    lamp_tmr_d = (tick_i && (lamp_tmr_q != '1)) ? lamp_tmr_q + TimerW'(1) : lamp_tmr_q;

    if (ev_i.light_press) begin
      st_d.lamp_on = !st_q.lamp_on;
      if (!st_q.lamp_on) lamp_tmr_d = '0;
    end

    // The radio edge detector holds its last level when the wall press wins.
    radio_prev_d = ev_i.wall_press ? radio_prev_q : radio_i;
    toggle = ev_i.wall_press || (radio_i && !radio_prev_q);
    if (toggle) begin
      if (st_d.moving) begin
        st_d.moving = 1'b0;
      end else begin
        st_d.going_up = !st_d.going_up;
        st_d.lamp_on  = 1'b1;
        st_d.moving   = 1'b1;
        lamp_tmr_d    = '0;
        run_d         = '0;
      end
    end

    if (!ev_i.up_level && st_d.going_up && st_d.moving) st_d.moving = 1'b0;
    if (!ev_i.dn_level && !st_d.going_up && st_d.moving) st_d.moving = 1'b0;
    if (st_d.moving && (run_d > {1'b0, max_run_ms_i})) st_d.moving = 1'b0;
    if (st_d.lamp_on && (lamp_tmr_d > {1'b0, max_lamp_ms_i})) st_d.lamp_on = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '{moving: 1'b0, going_up: 1'b1, lamp_on: 1'b0};
      radio_prev_q <= 1'b0;
      run_q        <= '0;
      lamp_tmr_q   <= '0;
    end else if (en_i) begin
      st_q         <= st_d;
      radio_prev_q <= radio_prev_d;
      run_q        <= run_d;
      lamp_tmr_q   <= lamp_tmr_d;
    end
  end

  assign status_d_o = st_d;
  assign status_q_o = st_q;

endmodule

>>> hw/rtl/garage_door_controller_top.sv
// Garage door controller top: one pin poll per word in, one drive word out.
// Uses gdc_pkg, gdc_debounce, gdc_ctrl and the macro header.
// Output: the result word is registered and is valid in the cycle after its poll word is taken.
// Throughput: one word per cycle; the output register frees itself in the cycle that its
// word is taken, so the input stalls only while a result word waits unread.
// Reset: default timings, door stopped and next run downwards, lamp off, output empty.
`include "garage_door_controller_top_macros.svh"
module garage_door_controller_top import gdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // bit 0 ms_tick, 1 wall_button, 2 radio_input, 3 light_button,
  // 4 upper_limit_pin, 5 lower_limit_pin, 7:6 zero
  input  logic [7:0]         s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // bit 0 motor_up_drive, 1 motor_down_drive, 2 lamp_drive, 3 moving_flag,
  // 7:4 zero
  output logic [7:0]         m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MaxW-1:0]    cfg_data_i
);

  logic            accept;
  logic            tick;
  logic [DebW-1:0] debounce_ms_q;
  logic [MaxW-1:0] max_run_q, max_lamp_q;
  logic            wall_fire, wall_lvl, light_fire, light_lvl;
  logic            up_fire, dn_fire;
  gdc_events_t     ev;
  gdc_status_t     st_d, st_q;
  logic            out_valid_q;
  logic [3:0]      out_q;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tdata[0];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= DebounceRst;
      max_run_q     <= MaxRunRst;
      max_lamp_q    <= MaxLampRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_MS: debounce_ms_q <= cfg_data_i[DebW-1:0];
        REG_MAX_RUN_MS:  max_run_q     <= cfg_data_i;
        REG_MAX_LAMP_MS: max_lamp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gdc_debounce u_wall (
    .clk_i, .rst_ni, .en_i(accept), .tick_i(tick), .pin_i(s_axis_tdata[1]),
    .blank_low_i(1'b0), .debounce_ms_i(debounce_ms_q),
    .fire_o(wall_fire), .level_o(wall_lvl)
  );

  gdc_debounce u_light (
    .clk_i, .rst_ni, .en_i(accept), .tick_i(tick), .pin_i(s_axis_tdata[3]),
    .blank_low_i(1'b0), .debounce_ms_i(debounce_ms_q),
    .fire_o(light_fire), .level_o(light_lvl)
  );

  gdc_debounce u_uplim (
    .clk_i, .rst_ni, .en_i(accept), .tick_i(tick), .pin_i(s_axis_tdata[4]),
    .blank_low_i(1'b1), .debounce_ms_i(debounce_ms_q),
    .fire_o(up_fire), .level_o(ev.up_level)
  );

  gdc_debounce u_dnlim (
    .clk_i, .rst_ni, .en_i(accept), .tick_i(tick), .pin_i(s_axis_tdata[5]),
    .blank_low_i(1'b1), .debounce_ms_i(debounce_ms_q),
    .fire_o(dn_fire), .level_o(ev.dn_level)
  );

  // A press is a newly accepted high level; a settled release does nothing.
  assign ev.wall_press  = wall_fire && wall_lvl;
  assign ev.light_press = light_fire && light_lvl;

  gdc_ctrl u_ctrl (
    .clk_i, .rst_ni, .en_i(accept), .tick_i(tick), .radio_i(s_axis_tdata[2]),
    .ev_i(ev), .max_run_ms_i(max_run_q), .max_lamp_ms_i(max_lamp_q),
    .status_d_o(st_d), .status_q_o(st_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {st_d.moving, st_d.lamp_on,
                st_d.moving && !st_d.going_up, st_d.moving && st_d.going_up};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  // Limit edges are not used directly; the accepted levels carry the meaning.
  logic unused_fire;
  assign unused_fire = up_fire ^ dn_fire;

  `GDC_ASSERT(a_one_direction, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
  `GDC_ASSERT(a_moving_matches, m_axis_tvalid |->
              (m_axis_tdata[3] == (m_axis_tdata[0] || m_axis_tdata[1])))
  `GDC_ASSERT(a_start_lights, $rose(st_q.moving) |-> st_q.lamp_on)
  `GDC_ASSERT(a_result_follows, accept |=> m_axis_tvalid)
  `GDC_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid || rst_ni)

endmodule
